// ===== rtl/core/jzes_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package jzes_pkg;

    localparam int NAME_MAX_BYTES = 512;

    localparam int DATA_W     = 8;
    localparam int NAME_LEN_W = 10;
    localparam int CSIZE_W    = 32;
    localparam int COUNT_W    = 16;
    localparam int VERDICT_W  = 2;
    localparam int KIND_W     = 2;
    localparam int M_TDATA_W  = 72;

    localparam logic [KIND_W-1:0] KIND_NAME    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_VERDICT = 2'd2;

    localparam logic [VERDICT_W-1:0] VERDICT_NOT_JPEG = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_JPEG     = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_JPEG_ZIP = 2'd2;

    localparam logic [7:0] SOI_BYTE0 = 8'hFF;
    localparam logic [7:0] SOI_BYTE1 = 8'hD8;
    localparam logic [7:0] SIG_BYTE0 = 8'h50;
    localparam logic [7:0] SIG_BYTE1 = 8'h4B;
    localparam logic [7:0] SIG_BYTE2 = 8'h03;
    localparam logic [7:0] SIG_BYTE3 = 8'h04;

    // results caused by one input byte, in output order: name, entry, verdict
    typedef struct packed {
        logic                  has_name;
        logic                  has_entry;
        logic                  has_verdict;
        logic [DATA_W-1:0]     name_byte;
        logic [NAME_LEN_W-1:0] name_length;
        logic [CSIZE_W-1:0]    comp_size;
        logic [COUNT_W-1:0]    entry_count;
        logic [VERDICT_W-1:0]  verdict;
    } res_bundle_t;

    function automatic logic [7:0] sig_byte(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = SIG_BYTE0;
            2'd1:    val = SIG_BYTE1;
            2'd2:    val = SIG_BYTE2;
            default: val = SIG_BYTE3;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/jzes_parse.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jzes_parse (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  wire logic [7:0]          data_byte,
    input  wire logic                end_of_stream,
    output jzes_pkg::res_bundle_t    bundle
);
    import jzes_pkg::*;

    typedef enum logic [2:0] {
        PH_SEEK_SOI,
        PH_SEEK_SIG,
        PH_HEADER,
        PH_NAME,
        PH_SKIP,
        PH_STOPPED
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [2:0]            match_reg, match_next;
    logic [4:0]            hdr_idx_reg, hdr_idx_next;
    logic [31:0]           size_reg, size_next;
    logic [15:0]           name_fld_reg, name_fld_next;
    logic [15:0]           extra_reg, extra_next;
    logic [NAME_LEN_W-1:0] left_reg, left_next;
    logic [NAME_LEN_W-1:0] taken_reg, taken_next;
    logic [32:0]           skip_reg, skip_next;
    logic [COUNT_W-1:0]    count_reg, count_next;

    logic [2:0]            idx;
    logic [2:0]            idx_n;
    logic [7:0]            expect_byte;
    logic [7:0]            first_byte;
    logic [1:0]            lane;

    always_comb
    begin
        phase_next    = phase_reg;
        match_next    = match_reg;
        hdr_idx_next  = hdr_idx_reg;
        size_next     = size_reg;
        name_fld_next = name_fld_reg;
        extra_next    = extra_reg;
        left_next     = left_reg;
        taken_next    = taken_reg;
        skip_next     = skip_reg;
        count_next    = count_reg;
        bundle        = '0;
        idx           = '0;
        idx_n         = '0;
        expect_byte   = '0;
        first_byte    = '0;
        lane          = 2'(hdr_idx_reg - 5'd14);

        case (phase_reg)
            PH_SEEK_SOI:
            begin
                idx         = (match_reg >= 3'd2) ? 3'd0 : match_reg;
                expect_byte = (idx == 3'd0) ? SOI_BYTE0 : SOI_BYTE1;
                idx_n       = (data_byte == expect_byte) ? idx + 3'd1
                            : ((data_byte == SOI_BYTE0) ? 3'd1 : 3'd0);
                if (idx_n == 3'd2)
                begin
                    match_next = '0;
                    phase_next = PH_SEEK_SIG;
                end
                else
                begin
                    match_next = idx_n;
                end
            end
            PH_SEEK_SIG:
            begin
                idx         = (match_reg >= 3'd4) ? 3'd0 : match_reg;
                expect_byte = sig_byte(idx[1:0]);
                first_byte  = sig_byte(2'd0);
                idx_n       = (data_byte == expect_byte) ? idx + 3'd1
                            : ((data_byte == first_byte) ? 3'd1 : 3'd0);
                if (idx_n == 3'd4)
                begin
                    match_next    = '0;
                    phase_next    = PH_HEADER;
                    hdr_idx_next  = '0;
                    size_next     = '0;
                    name_fld_next = '0;
                    extra_next    = '0;
                end
                else
                begin
                    match_next = idx_n;
                end
            end
            PH_HEADER:
            begin
                if (hdr_idx_reg >= 5'd14 && hdr_idx_reg <= 5'd17)
                    size_next[lane*8 +: 8] = data_byte;
                else if (hdr_idx_reg == 5'd22 || hdr_idx_reg == 5'd23)
                    name_fld_next[hdr_idx_reg[0]*8 +: 8] = data_byte;
                else if (hdr_idx_reg == 5'd24 || hdr_idx_reg == 5'd25)
                    extra_next[hdr_idx_reg[0]*8 +: 8] = data_byte;

                if (hdr_idx_reg >= 5'd25)
                begin
                    hdr_idx_next = '0;
                    if (name_fld_next == 16'd0 || end_of_stream)
                    begin
                        phase_next = PH_STOPPED;
                    end
                    else
                    begin
                        left_next  = (name_fld_next < 16'(NAME_MAX_BYTES))
                                   ? NAME_LEN_W'(name_fld_next)
                                   : NAME_LEN_W'(NAME_MAX_BYTES);
                        taken_next = '0;
                        phase_next = PH_NAME;
                    end
                end
                else
                begin
                    hdr_idx_next = hdr_idx_reg + 5'd1;
                end
            end
            PH_NAME:
            begin
                bundle.has_name  = 1'b1;
                bundle.name_byte = data_byte;
                taken_next       = taken_reg + 1'b1;
                left_next        = (left_reg != '0) ? left_reg - 1'b1 : left_reg;
                if (left_next == '0 || end_of_stream)
                begin
                    if (count_reg != '1)
                        count_next = count_reg + 1'b1;
                    bundle.has_entry   = 1'b1;
                    bundle.name_length = taken_next;
                    bundle.comp_size   = size_reg;
                    skip_next  = {1'b0, size_reg} + {17'd0, extra_reg};
                    match_next = '0;
                    phase_next = (skip_next != '0) ? PH_SKIP : PH_SEEK_SIG;
                end
            end
            PH_SKIP:
            begin
                if (skip_reg != '0)
                    skip_next = skip_reg - 1'b1;
                if (skip_next == '0)
                begin
                    match_next = '0;
                    phase_next = PH_SEEK_SIG;
                end
            end
            default:
            begin
            end
        endcase

        bundle.entry_count = count_next;

        if (end_of_stream)
        begin
            bundle.has_verdict = 1'b1;
            if (phase_next == PH_SEEK_SOI)
                bundle.verdict = VERDICT_NOT_JPEG;
            else if (count_next == '0)
                bundle.verdict = VERDICT_JPEG;
            else
                bundle.verdict = VERDICT_JPEG_ZIP;
            phase_next    = PH_SEEK_SOI;
            match_next    = '0;
            hdr_idx_next  = '0;
            size_next     = '0;
            name_fld_next = '0;
            extra_next    = '0;
            left_next     = '0;
            taken_next    = '0;
            skip_next     = '0;
            count_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_SEEK_SOI;
            match_reg    <= '0;
            hdr_idx_reg  <= '0;
            size_reg     <= '0;
            name_fld_reg <= '0;
            extra_reg    <= '0;
            left_reg     <= '0;
            taken_reg    <= '0;
            skip_reg     <= '0;
            count_reg    <= '0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            match_reg    <= match_next;
            hdr_idx_reg  <= hdr_idx_next;
            size_reg     <= size_next;
            name_fld_reg <= name_fld_next;
            extra_reg    <= extra_next;
            left_reg     <= left_next;
            taken_reg    <= taken_next;
            skip_reg     <= skip_next;
            count_reg    <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/jpeg_zip_entry_scanner.sv =====
`timescale 1ns / 1ps
`default_nettype none
// JPEG start marker / appended ZIP local header scanner.
// Input stream: one file byte per transfer on s_tdata, s_tlast marks the
// final byte of a stream. Output stream: name bytes (kind 0), an entry
// report after each parsed local header and its name (kind 1), and a final
// verdict (kind 2) after the last byte; kind travels on m_tuser and m_tlast
// marks the last result caused by one input byte.
// Latency: the results of a byte appear the cycle after its transfer.
// Throughput: one byte per cycle while each byte causes at most one result
// and m_tready is high; after a byte causing k results (k is at most 3),
// the next byte is taken in the cycle its last result transfers. Bytes
// causing no result pass at one per cycle regardless of the output. The
// limit is the single result register, drained one result per ready cycle.
// Stall: a waiting result holds m_tdata/m_tuser/m_tlast steady; s_tready
// drops while results are pending unless one remains and m_tready is high.
// Reset: output empties and the scanner returns to hunting for FF D8 with
// the entry count cleared; each s_tlast byte restarts the hunt likewise.
module jpeg_zip_entry_scanner (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [7:0]                     s_tdata,  // data_byte
    input  wire logic                           s_tlast,  // end_of_stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // name_byte[7:0], name_length[17:8], comp_size[49:18],
    // entry_count[65:50], verdict[67:66], zero pad [71:68]
    output logic [jzes_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic [jzes_pkg::KIND_W-1:0]         m_tuser,  // kind
    output logic                                m_tlast   // last_result
);
    import jzes_pkg::*;

    res_bundle_t bundle;
    res_bundle_t res_reg;
    logic [2:0]  pend_reg, pend_next;
    logic        take;
    logic        m_xfer;
    logic        single;
    logic [2:0]  lowest;

    jzes_parse u_parse (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .data_byte     (s_tdata),
        .end_of_stream (s_tlast),
        .bundle        (bundle)
    );

    // pend_reg bit 0 name, bit 1 entry, bit 2 verdict
    assign single   = (pend_reg != 3'd0) && ((pend_reg & (pend_reg - 3'd1)) == 3'd0);
    assign lowest   = pend_reg & (~pend_reg + 3'd1);
    assign m_tvalid = (pend_reg != 3'd0);
    assign m_xfer   = m_tvalid && m_tready;
    assign s_tready = (pend_reg == 3'd0) || (m_tready && single);
    assign take     = s_tvalid && s_tready;

    always_comb
    begin
        pend_next = pend_reg;
        if (m_xfer)
            pend_next = pend_reg & ~lowest;
        if (take)
            pend_next = {bundle.has_verdict, bundle.has_entry, bundle.has_name};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            res_reg <= bundle;
    end

    always_comb
    begin
        m_tdata = '0;
        m_tuser = KIND_VERDICT;
        m_tlast = single;
        if (pend_reg[0])
        begin
            m_tuser      = KIND_NAME;
            m_tdata[7:0] = res_reg.name_byte;
        end
        else if (pend_reg[1])
        begin
            m_tuser        = KIND_ENTRY;
            m_tdata[17:8]  = res_reg.name_length;
            m_tdata[49:18] = res_reg.comp_size;
            m_tdata[65:50] = res_reg.entry_count;
        end
        else
        begin
            m_tdata[65:50] = res_reg.entry_count;
            m_tdata[67:66] = res_reg.verdict;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/jzes_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module jzes_checker (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [jzes_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic [jzes_pkg::KIND_W-1:0]    m_tuser,
    input  wire logic                           m_tlast
);
    import jzes_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_VERDICT |-> m_tlast)
        else $error("verdict is not the last result of its byte");

    a_name_then_entry: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tuser == KIND_NAME && !m_tlast
            |=> m_tvalid && m_tuser == KIND_ENTRY)
        else $error("non-final name byte not followed by entry report");

    a_name_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_NAME |-> m_tdata[M_TDATA_W-1:8] == '0)
        else $error("name byte result carries stray fields");

    a_no_take_mid_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("input taken while a multi-result transfer is pending");

endmodule

bind jpeg_zip_entry_scanner jzes_checker u_jzes_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
